### hdl/quoted_field_tokenizer_core_macros.svh
// Assertion macros for the quoted field tokenizer checker.
// Used by hdl/qft_checker.sv; no other dependencies.
`ifndef QUOTED_FIELD_TOKENIZER_CORE_MACROS_SVH
`define QUOTED_FIELD_TOKENIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QFT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("qft check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("qft check failed");

// Implication that is checked during reset as well.
`define QFT_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("qft check failed");

`endif

### hdl/qft_pkg.sv
// Shared types and constants of the quoted field tokenizer.
// No dependencies; imported by every other file of the block but the macro header.
package qft_pkg;

  localparam int unsigned MapRegs   = 4;
  localparam int unsigned MapRegW   = 64;
  localparam int unsigned CfgIndexW = 8;

  localparam logic [7:0] DQUOTE = 8'h22;
  localparam logic [7:0] SQUOTE = 8'h27;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_SEP_MAP_0 = 8'd0;
  localparam logic [CfgIndexW-1:0] CFG_SEP_MAP_1 = 8'd1;
  localparam logic [CfgIndexW-1:0] CFG_SEP_MAP_2 = 8'd2;
  localparam logic [CfgIndexW-1:0] CFG_SEP_MAP_3 = 8'd3;

  localparam logic [MapRegW-1:0] SEP_MAP_0_RST = 64'h0000_0001_0000_0000;

  typedef enum logic [1:0] {
    KIND_BYTE       = 2'd0,
    KIND_TOKEN_END  = 2'd1,
    KIND_STRING_END = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_PLAIN   = 2'd1,
    MODE_QUOTED  = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e      mode;
    logic       quote_single;
    logic [1:0] run_cnt;
    logic [7:0] run_first;
    logic       run_match;
  } scan_state_t;

  // Pending results of one byte, emitted lowest bit first:
  // bit 0 empty-token end, bit 1 token byte, bit 2 token end, bit 3 string end.
  typedef struct packed {
    logic [3:0] pend;
    logic [7:0] data;
  } res_set_t;

endpackage

### hdl/qft_decode.sv
// Per-byte decision logic: separator lookup, scan state update, result set.
// Depends on qft_pkg.
module qft_decode (
  input  logic [7:0]                                    char_i,
  input  logic                                          eos_i,
  input  logic [qft_pkg::MapRegs-1:0][qft_pkg::MapRegW-1:0] sep_map_i,
  input  qft_pkg::scan_state_t                          state_i,
  output qft_pkg::scan_state_t                          state_o,
  output qft_pkg::res_set_t                             res_o
);
  import qft_pkg::*;

  logic       is_sep;
  logic [7:0] close_quote;

  assign is_sep      = (char_i == 8'd0) || sep_map_i[char_i[7:6]][char_i[5:0]];
  assign close_quote = state_i.quote_single ? SQUOTE : DQUOTE;

  always_comb begin
    state_o  = state_i;
    res_o    = '0;
    res_o.data = char_i;

    unique case (state_i.mode)
      MODE_BETWEEN: begin
        if (is_sep) begin
          if (state_i.run_cnt == 2'd0) begin
            state_o.run_first = char_i;
            state_o.run_cnt   = 2'd1;
            state_o.run_match = 1'b1;
          end else begin
            state_o.run_cnt   = 2'd2;
            state_o.run_match = (char_i == state_i.run_first);
          end
          res_o.pend[2] = eos_i && (state_o.run_cnt == 2'd2) && state_o.run_match;
        end else begin
          res_o.pend[0]     = (state_i.run_cnt == 2'd2) && state_i.run_match;
          state_o.run_cnt   = 2'd0;
          state_o.run_first = 8'd0;
          state_o.run_match = 1'b0;
          if ((char_i == DQUOTE) || (char_i == SQUOTE)) begin
            state_o.mode         = MODE_QUOTED;
            state_o.quote_single = (char_i == SQUOTE);
          end else begin
            state_o.mode  = MODE_PLAIN;
            res_o.pend[1] = 1'b1;
          end
          res_o.pend[2] = eos_i;
        end
      end
      MODE_PLAIN: begin
        if (is_sep) begin
          res_o.pend[2]     = 1'b1;
          state_o.mode      = MODE_BETWEEN;
          state_o.run_cnt   = 2'd1;
          state_o.run_first = char_i;
          state_o.run_match = 1'b1;
        end else begin
          res_o.pend[1] = 1'b1;
          res_o.pend[2] = eos_i;
        end
      end
      default: begin
        // quoted token: only the matching quote or the end of the string ends it
        if (char_i == close_quote) begin
          res_o.pend[2]     = 1'b1;
          state_o.mode      = MODE_BETWEEN;
          state_o.run_cnt   = 2'd0;
          state_o.run_first = 8'd0;
          state_o.run_match = 1'b0;
        end else begin
          res_o.pend[1] = 1'b1;
          res_o.pend[2] = eos_i;
        end
      end
    endcase

    if (eos_i) begin
      res_o.pend[3]        = 1'b1;
      state_o.mode         = MODE_BETWEEN;
      state_o.quote_single = 1'b0;
      state_o.run_cnt      = 2'd0;
      state_o.run_first    = 8'd0;
      state_o.run_match    = 1'b0;
    end
  end

endmodule

### hdl/qft_emit.sv
// Result register: holds the pending results of one byte and sends them
// one per transaction. Depends on qft_pkg.
module qft_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  qft_pkg::res_set_t res_i,
  output logic              can_load_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast
);
  import qft_pkg::*;

  logic [3:0] pend_q, pend_d;
  logic [7:0] data_q, data_d;
  logic [3:0] sel;
  logic [3:0] rest;
  logic       fire;
  kind_e      kind;

  assign sel  = pend_q & (~pend_q + 4'd1);  // lowest pending result
  assign rest = pend_q & ~sel;
  assign fire = m_axis_tvalid && m_axis_tready;

  assign can_load_o = (pend_q == 4'd0) || (fire && (rest == 4'd0));

  always_comb begin
    priority case (1'b1)
      sel[1]:  kind = KIND_BYTE;
      sel[3]:  kind = KIND_STRING_END;
      default: kind = KIND_TOKEN_END;
    endcase
  end

  assign m_axis_tvalid = (pend_q != 4'd0);
  assign m_axis_tuser  = kind;
  assign m_axis_tdata  = sel[1] ? data_q : 8'd0;
  assign m_axis_tlast  = (rest == 4'd0);

  always_comb begin
    pend_d = pend_q;
    data_d = data_q;
    if (fire) begin
      pend_d = rest;
    end
    if (load_i) begin
      pend_d = res_i.pend;
      data_d = res_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 4'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

### hdl/quoted_field_tokenizer_core.sv
// Quoted field tokenizer, top level: config registers, input register,
// scan state. Depends on qft_pkg, qft_decode, qft_emit.
//
// Usage
// - Input stream s_axis: one string byte per transaction, tlast on the final
//   byte of each string. Strings are at least one byte long.
// - Output stream m_axis: one result per transaction. tuser gives the kind
//   (token byte, end of token, end of string), tdata the byte for token
//   bytes and zero otherwise, tlast marks the final result of an input byte.
//   A byte gives zero to four results.
// - cfg port: writes the four 64-bit separator map registers by index;
//   cfg_ready_o is always high, other indexes are ignored. Write only while
//   the block is idle. Byte 0 is a separator whatever the map says.
// - Path: a byte taken passes the input register, then the result register, before it can leave.
// - Throughput: one byte per cycle while m_axis_tready is high and each byte
//   yields at most one result; a byte with more results holds the result
//   register until all are sent, the single result register being the limit.
// - Stall: with m_axis_tready low, the input register still takes one byte,
//   then s_axis_tready drops until the result register drains.
// - Reset (asynchronous, active low): empties both registers, returns the
//   scanner to between tokens and sets the map to space only.
module quoted_field_tokenizer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [qft_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [qft_pkg::MapRegW-1:0]   cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] char_in
  input  logic                          s_axis_tlast,   // end_of_string
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [7:0] token_byte
  output logic [1:0]                    m_axis_tuser,   // [1:0] kind
  output logic                          m_axis_tlast    // last_of_run
);
  import qft_pkg::*;

  logic [MapRegs-1:0][MapRegW-1:0] sep_map_q, sep_map_d;
  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_char_q, in_char_d;
  logic        in_eos_q, in_eos_d;
  scan_state_t state_q, state_d, state_nxt;
  res_set_t    res;
  logic        can_load;
  logic        advance;
  logic        s_fire;

  // Config: always ready, one register per transaction
  assign cfg_ready_o = 1'b1;

  always_comb begin
    sep_map_d = sep_map_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SEP_MAP_0: sep_map_d[0] = cfg_data_i;
        CFG_SEP_MAP_1: sep_map_d[1] = cfg_data_i;
        CFG_SEP_MAP_2: sep_map_d[2] = cfg_data_i;
        CFG_SEP_MAP_3: sep_map_d[3] = cfg_data_i;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Input register; byte moves on when the result register can take it
  assign advance       = in_valid_q && can_load;
  assign s_axis_tready = !in_valid_q || can_load;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q && !advance;
    in_char_d  = in_char_q;
    in_eos_d   = in_eos_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
      in_char_d  = s_axis_tdata;
      in_eos_d   = s_axis_tlast;
    end
  end

  // Scan state moves with the byte into the result register
  assign state_d = advance ? state_nxt : state_q;

  qft_decode u_decode (
    .char_i    (in_char_q),
    .eos_i     (in_eos_q),
    .sep_map_i (sep_map_q),
    .state_i   (state_q),
    .state_o   (state_nxt),
    .res_o     (res)
  );

  qft_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance),
    .res_i         (res),
    .can_load_o    (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_map_q  <= {{(MapRegs-1)*MapRegW{1'b0}}, SEP_MAP_0_RST};
      in_valid_q <= 1'b0;
      state_q    <= '{mode: MODE_BETWEEN, quote_single: 1'b0, run_cnt: 2'd0,
                      run_first: 8'd0, run_match: 1'b0};
    end else begin
      sep_map_q  <= sep_map_d;
      in_valid_q <= in_valid_d;
      state_q    <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_char_q <= in_char_d;
    in_eos_q  <= in_eos_d;
  end

endmodule

### hdl/qft_checker.sv
// Port-level checks of the quoted field tokenizer, bound to the top level.
// Depends on qft_pkg and quoted_field_tokenizer_core_macros.svh.
`include "quoted_field_tokenizer_core_macros.svh"

module qft_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [qft_pkg::CfgIndexW-1:0] cfg_index_i,
  input logic [qft_pkg::MapRegW-1:0]   cfg_data_i,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [7:0]                    s_axis_tdata,   // [7:0] char_in
  input logic                          s_axis_tlast,   // end_of_string
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [7:0]                    m_axis_tdata,   // [7:0] token_byte
  input logic [1:0]                    m_axis_tuser,   // [1:0] kind
  input logic                          m_axis_tlast    // last_of_run
);
  import qft_pkg::*;

  // stalled result holds
  `QFT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // only token bytes carry data
  `QFT_ASSERT_NOW(a_data_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != KIND_BYTE), m_axis_tdata == 8'd0)

  // end of string is always the final result of its byte
  `QFT_ASSERT_NOW(a_str_end_last, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == KIND_STRING_END), m_axis_tlast)

  // nothing offered while in reset
  `QFT_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni, !m_axis_tvalid)

endmodule

bind quoted_field_tokenizer_core qft_checker u_qft_checker (.*);

### verif/quoted_field_tokenizer_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for quoted_field_tokenizer_core: scoreboard package
// with a tokenizer predictor, then the top module that drives the streams.
// Depends on qft_pkg and the RTL of the block.

package qft_tb_pkg;
  import qft_pkg::*;

  typedef struct {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } tok_result_t;

  class token_scoreboard;
    logic [MapRegW-1:0] sep_map [MapRegs];
    mode_e              mode;
    logic               quote_single;
    logic [1:0]         run_cnt;
    logic [7:0]         run_first;
    logic               run_match;

    tok_result_t awaited [$];
    int          failures;
    int          bytes_seen;
    int          strings_seen;
    int          results_seen;
    int          kind_seen [3];

    function new();
      sep_map[0]   = SEP_MAP_0_RST;
      sep_map[1]   = '0;
      sep_map[2]   = '0;
      sep_map[3]   = '0;
      mode         = MODE_BETWEEN;
      quote_single = 1'b0;
      clear_run();
    endfunction

    function void clear_run();
      run_cnt   = 2'd0;
      run_first = 8'h00;
      run_match = 1'b0;
    endfunction

    function bit is_separator(logic [7:0] c);
      return (c == 8'h00) || sep_map[c[7:6]][c[5:0]];
    endfunction

    // indexes past the last map register are dropped by the block
    function void load_map(logic [CfgIndexW-1:0] idx, logic [MapRegW-1:0] val);
      if (idx < MapRegs) sep_map[idx] = val;
    endfunction

    function void add_result(kind_e kind, logic [7:0] data);
      tok_result_t r;
      r.kind = kind;
      r.data = data;
      r.last = 1'b0;
      awaited.push_back(r);
    endfunction

    // Advances the tokenizer state by one accepted byte and queues its results.
    function void note_byte(logic [7:0] c, logic eos);
      int         first_new;
      logic       sep;
      logic [7:0] closer;
      first_new = awaited.size();
      sep       = is_separator(c);
      bytes_seen++;
      case (mode)
        MODE_BETWEEN: begin
          if (sep) begin
            if (run_cnt == 2'd0) begin
              run_first = c;
              run_cnt   = 2'd1;
            end else begin
              run_cnt = 2'd2;
            end
            run_match = (c == run_first);
            if (eos && run_cnt == 2'd2 && run_match) add_result(KIND_TOKEN_END, 8'h00);
          end else begin
            if (run_cnt == 2'd2 && run_match) add_result(KIND_TOKEN_END, 8'h00);
            clear_run();
            if (c == DQUOTE || c == SQUOTE) begin
              mode         = MODE_QUOTED;
              quote_single = (c == SQUOTE);
            end else begin
              mode = MODE_PLAIN;
              add_result(KIND_BYTE, c);
            end
            if (eos) add_result(KIND_TOKEN_END, 8'h00);
          end
        end
        MODE_PLAIN: begin
          if (sep) begin
            add_result(KIND_TOKEN_END, 8'h00);
            mode      = MODE_BETWEEN;
            run_cnt   = 2'd1;
            run_first = c;
            run_match = 1'b1;
          end else begin
            add_result(KIND_BYTE, c);
            if (eos) add_result(KIND_TOKEN_END, 8'h00);
          end
        end
        default: begin
          closer = quote_single ? SQUOTE : DQUOTE;
          if (c == closer) begin
            add_result(KIND_TOKEN_END, 8'h00);
            mode = MODE_BETWEEN;
            clear_run();
          end else begin
            add_result(KIND_BYTE, c);
            if (eos) add_result(KIND_TOKEN_END, 8'h00);
          end
        end
      endcase
      if (eos) begin
        add_result(KIND_STRING_END, 8'h00);
        mode         = MODE_BETWEEN;
        quote_single = 1'b0;
        clear_run();
        strings_seen++;
      end
      if (awaited.size() > first_new) awaited[awaited.size()-1].last = 1'b1;
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
      tok_result_t want;
      results_seen++;
      if (kind < 2'd3) kind_seen[kind]++;
      if (awaited.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, got kind %0d data %02h last %0b",
                 $time, kind, data, last);
        return;
      end
      want = awaited.pop_front();
      if (kind !== want.kind || data !== want.data || last !== want.last) begin
        failures++;
        $display("%0t: result mismatch, expected kind %0d data %02h last %0b,",
                 $time, want.kind, want.data, want.last);
        $display("%0t:   got kind %0d data %02h last %0b", $time, kind, data, last);
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass
endpackage

module quoted_field_tokenizer_core_tb;
  import qft_pkg::*;
  import qft_tb_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 6;    // result path is two registers deep
  localparam int HoldCycles    = 80;   // long receiver hold-off
  localparam int BytesPerPhase = 27;

  // writes here must leave the map untouched
  localparam logic [CfgIndexW-1:0] CFG_SPARE_FIRST = CFG_SEP_MAP_3 + 1'b1;
  localparam logic [CfgIndexW-1:0] CFG_SPARE_LAST  = {CfgIndexW{1'b1}};
  localparam logic [CfgIndexW-1:0] MAP_INDEX [MapRegs] =
    '{CFG_SEP_MAP_0, CFG_SEP_MAP_1, CFG_SEP_MAP_2, CFG_SEP_MAP_3};

  localparam logic [7:0] SPACE = 8'h20;
  localparam logic [7:0] COMMA = 8'h2c;
  localparam logic [7:0] TAB   = 8'h09;
  localparam logic [7:0] PIPE  = 8'h7c;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [MapRegW-1:0]   cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // [7:0] char_in
  logic                 s_axis_tlast;   // end_of_string
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [7:0]           m_axis_tdata;   // [7:0] token_byte
  logic [1:0]           m_axis_tuser;   // [1:0] kind
  logic                 m_axis_tlast;   // last_of_run

  token_scoreboard sb;
  int  maps_used;
  int  idle_cycles;
  int  hold_left;
  bit  hold_request;
  bit  hold_taken;
  bit  no_gaps;

  quoted_field_tokenizer_core uut (.*);

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Receiver: random back-pressure, one long hold-off on request, none at
  // all while no_gaps is set.
  always @(posedge clk_i) begin
    if (hold_request && !hold_taken) begin
      hold_left  = HoldCycles;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 34);
    end
  end

  // Output monitor; values read here are the ones from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, WatchdogLimit);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic eos);
    while (!no_gaps && $urandom_range(0, 99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eos;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_byte(c, eos);
  endtask

  task automatic send_string(input logic [7:0] s [$]);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  // Sender pauses until every awaited result is out and the pipe is empty.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // All four map registers in one burst, then a write to an unused index.
  task automatic load_maps(input logic [MapRegW-1:0] m0, m1, m2, m3);
    logic [MapRegW-1:0]   vals [MapRegs];
    logic [CfgIndexW-1:0] idx;
    logic [MapRegW-1:0]   val;
    vals = '{m0, m1, m2, m3};
    drain();
    for (int i = 0; i <= MapRegs; i++) begin
      if (i < MapRegs) begin
        idx = MAP_INDEX[i];
        val = vals[i];
      end else begin
        idx = CfgIndexW'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST));
        val = {$urandom(), $urandom()};
      end
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= val;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.load_map(idx, val);
    end
    cfg_valid_i <= 1'b0;
    maps_used++;
  endtask

  function automatic logic [7:0] pick_separator();
    logic [7:0] c;
    repeat (40) begin
      c = 8'($urandom_range(0, 255));
      if (sb.is_separator(c)) return c;
    end
    return 8'h00;
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    repeat (40) begin
      c = 8'($urandom_range(0, 255));
      if (!sb.is_separator(c) && c != DQUOTE && c != SQUOTE) return c;
    end
    return c;
  endfunction

  // Mostly well-formed strings: separator runs between plain or quoted
  // tokens; the rest is noise heavy on zeros, quotes and 0xff.
  function automatic void make_string(ref logic [7:0] s [$]);
    int         n;
    logic [7:0] c;
    logic [7:0] opener;
    s.delete();
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 5))
          0:       c = 8'h00;
          1:       c = DQUOTE;
          2:       c = SQUOTE;
          3:       c = 8'hff;
          default: c = 8'($urandom_range(0, 255));
        endcase
        s.push_back(c);
      end
      return;
    end
    repeat ($urandom_range(1, 3)) begin
      n = $urandom_range(0, 3);
      c = pick_separator();
      repeat (n) begin
        s.push_back(c);
        if ($urandom_range(0, 2) == 0) c = pick_separator();
      end
      if ($urandom_range(0, 2) == 0) begin
        opener = $urandom_range(0, 1) ? SQUOTE : DQUOTE;
        s.push_back(opener);
        repeat ($urandom_range(0, 3)) begin
          c = 8'($urandom_range(0, 255));
          if (c == opener) c ^= 8'h01;
          s.push_back(c);
        end
        // a fifth of quoted tokens stay open until the string ends
        if ($urandom_range(0, 4) != 0) s.push_back(opener);
      end else begin
        repeat ($urandom_range(1, 4)) s.push_back(pick_plain());
      end
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) s.push_back(pick_separator());
  endfunction

  task automatic random_phase(input int count);
    logic [7:0] s [$];
    int         stop_at;
    stop_at = sb.bytes_seen + count;
    while (sb.bytes_seen < stop_at) begin
      make_string(s);
      send_string(s);
    end
  endtask

  initial begin
    sb            = new();
    maps_used     = 1;
    idle_cycles   = 0;
    hold_left     = 0;
    hold_request  = 1'b0;
    hold_taken    = 1'b0;
    no_gaps       = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings on the reset map (space only).
    // single plain byte that also ends the string
    send_string('{8'h61});
    // lone opening quote closed by end of string
    send_string('{DQUOTE});
    // empty token from two equal separators, then a byte ending the string:
    // four results from one byte
    send_string('{SPACE, SPACE, 8'h78});
    // separators, byte zero and the other quote are data inside quotes
    send_string('{SQUOTE, SPACE, 8'h00, DQUOTE, SQUOTE, 8'h7a});
    // quote inside a plain token, empty token at the end of the string
    send_string('{8'h61, DQUOTE, 8'h62, SPACE, SPACE});
    // byte extremes; byte zero separates though absent from the map
    send_string('{8'hff, 8'h00, 8'h00, 8'h7f});
    // unterminated quote with content
    send_string('{DQUOTE, 8'h71});

    // Quotes, comma, tab, space, pipe and 0xff separate: a quote between
    // tokens is skipped, two equal ones give an empty token.
    load_maps((64'd1 << TAB) | (64'd1 << SPACE) | (64'd1 << DQUOTE) |
              (64'd1 << SQUOTE) | (64'd1 << COMMA),
              64'd1 << (PIPE - 8'd64), 64'd0, 64'h8000_0000_0000_0000);
    send_string('{DQUOTE, DQUOTE, 8'h6b});

    // receiver holds off for a long stretch while bytes keep coming
    hold_request = 1'b1;
    random_phase(BytesPerPhase);

    load_maps('0, '0, '0, '0);
    random_phase(BytesPerPhase);

    // every byte separates; no gaps on either side
    load_maps('1, '1, '1, '1);
    no_gaps = 1'b1;
    random_phase(BytesPerPhase);
    no_gaps = 1'b0;

    repeat (2) begin
      load_maps({$urandom(), $urandom()}, {$urandom(), $urandom()},
                {$urandom(), $urandom()}, {$urandom(), $urandom()});
      random_phase(BytesPerPhase);
    end

    load_maps(SEP_MAP_0_RST, '0, '0, '0);
    random_phase(BytesPerPhase);

    drain();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Covered %0d bytes in %0d strings under %0d separator maps, with a long",
             sb.bytes_seen, sb.strings_seen, maps_used);
    $display("output hold-off; %0d results: %0d token bytes, %0d token ends, %0d string ends",
             sb.results_seen, sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2]);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0t: %0d failures, %0d results never arrived",
               $time, sb.failures, sb.outstanding());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
